/* rtl/prewitt_edge_banded_threshold_defines.svh */
// Assertion macros for the banded Prewitt edge block.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef PREWITT_EDGE_BANDED_THRESHOLD_DEFINES_SVH
`define PREWITT_EDGE_BANDED_THRESHOLD_DEFINES_SVH

// same-cycle implication
`define PEBT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pebt: same-cycle check failed");

// next-cycle implication
`define PEBT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pebt: next-cycle check failed");

`endif

/* rtl/pebt_pkg.sv */
// Types, constants and band selection for the banded Prewitt edge block.
// No dependencies.
`default_nettype none

package pebt_pkg;

	typedef logic [1:0] band_t;
	typedef logic [7:0] pixel_t;

	localparam int unsigned NUM_BANDS = 4;

	// register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_DARK_BAND0 = 3'd0,
		REG_DARK_BAND1 = 3'd1,
		REG_DARK_BAND2 = 3'd2,
		REG_DARK_BAND3 = 3'd3,
		REG_GRAD_BAND0 = 3'd4,
		REG_GRAD_BAND1 = 3'd5,
		REG_GRAD_BAND2 = 3'd6,
		REG_GRAD_BAND3 = 3'd7
	} reg_index_t;

	localparam logic [7:0] BAND0_ROW_MIN = 8'd110;
	localparam logic [7:0] BAND1_ROW_MIN = 8'd80;
	localparam logic [7:0] BAND2_ROW_MIN = 8'd60;

	localparam band_t BAND0 = 2'd0;
	localparam band_t BAND1 = 2'd1;
	localparam band_t BAND2 = 2'd2;
	localparam band_t BAND3 = 2'd3;

	function automatic band_t pick_band(input logic [7:0] row);
		band_t b;
		priority if (row >= BAND0_ROW_MIN) b = BAND0;
		else if (row >= BAND1_ROW_MIN) b = BAND1;
		else if (row >= BAND2_ROW_MIN) b = BAND2;
		else b = BAND3;
		return b;
	endfunction

	// |a - b| of two 10-bit column/row sums
	function automatic logic [9:0] abs_diff(input logic [9:0] a, input logic [9:0] b);
		logic [9:0] d;
		if (a >= b) d = a - b;
		else d = b - a;
		return d;
	endfunction

endpackage

`default_nettype wire

/* rtl/prewitt_edge_banded_threshold.sv */
// Banded Prewitt edge test on one 3x3 window per clock.
// Depends on pebt_pkg and prewitt_edge_banded_threshold_defines.svh.
//
// Takes one window per clock: a request is taken at any edge where start is high (busy
// stays low). The result appears on is_edge with done high for one cycle, after the
// three register stages (input, gradient, result). The receiver cannot stall, so each
// result must be taken as it appears. Configuration registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no request is in
// flight, which the block itself does not enforce.
`default_nettype none
`include "prewitt_edge_banded_threshold_defines.svh"

module prewitt_edge_banded_threshold (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [7:0]  row_index,
	input  wire logic [7:0]  top_left,
	input  wire logic [7:0]  top_mid,
	input  wire logic [7:0]  top_right,
	input  wire logic [7:0]  mid_left,
	input  wire logic [7:0]  center_pixel,
	input  wire logic [7:0]  mid_right,
	input  wire logic [7:0]  bottom_left,
	input  wire logic [7:0]  bottom_mid,
	input  wire logic [7:0]  bottom_right,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             done,
	output logic             is_edge
);

	logic [7:0]  dark_level_q [pebt_pkg::NUM_BANDS];
	logic [15:0] grad_limit_q [pebt_pkg::NUM_BANDS];

	// stage 1: input register
	logic            valid_s1;
	logic [7:0]      row_s1;
	pebt_pkg::pixel_t tl_s1, tm_s1, tr_s1, ml_s1, c_s1, mr_s1, bl_s1, bm_s1, br_s1;

	// stage 2: gradient magnitudes and band decisions
	logic        valid_s2;
	logic        dark_s2;
	logic [9:0]  gx_abs_s2;
	logic [9:0]  gy_abs_s2;
	logic [15:0] limit_s2;

	// stage 3: result
	logic done_q;
	logic is_edge_q;

	pebt_pkg::band_t band;
	logic [9:0]  top_sum, bot_sum, left_sum, right_sum;
	logic [19:0] gx_sq, gy_sq;
	logic [20:0] mag;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pebt_pkg::NUM_BANDS; i++) begin
				dark_level_q[i] <= '0;
				grad_limit_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (pebt_pkg::reg_index_t'(cfg_index))
				pebt_pkg::REG_DARK_BAND0: dark_level_q[0] <= cfg_data[7:0];
				pebt_pkg::REG_DARK_BAND1: dark_level_q[1] <= cfg_data[7:0];
				pebt_pkg::REG_DARK_BAND2: dark_level_q[2] <= cfg_data[7:0];
				pebt_pkg::REG_DARK_BAND3: dark_level_q[3] <= cfg_data[7:0];
				pebt_pkg::REG_GRAD_BAND0: grad_limit_q[0] <= cfg_data;
				pebt_pkg::REG_GRAD_BAND1: grad_limit_q[1] <= cfg_data;
				pebt_pkg::REG_GRAD_BAND2: grad_limit_q[2] <= cfg_data;
				pebt_pkg::REG_GRAD_BAND3: grad_limit_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			done_q    <= 1'b0;
			is_edge_q <= 1'b0;
		end else begin
			valid_s1  <= start & ~busy;
			valid_s2  <= valid_s1;
			done_q    <= valid_s2;
			is_edge_q <= valid_s2 & dark_s2 & (mag > {5'd0, limit_s2});
		end
	end

	// payload
	always_ff @(posedge clk) begin
		row_s1 <= row_index;
		tl_s1  <= top_left;
		tm_s1  <= top_mid;
		tr_s1  <= top_right;
		ml_s1  <= mid_left;
		c_s1   <= center_pixel;
		mr_s1  <= mid_right;
		bl_s1  <= bottom_left;
		bm_s1  <= bottom_mid;
		br_s1  <= bottom_right;

		dark_s2   <= c_s1 < dark_level_q[band];
		limit_s2  <= grad_limit_q[band];
		gx_abs_s2 <= pebt_pkg::abs_diff(bot_sum, top_sum);
		gy_abs_s2 <= pebt_pkg::abs_diff(right_sum, left_sum);
	end

	always_comb begin
		band      = pebt_pkg::pick_band(row_s1);
		top_sum   = 10'(tl_s1) + 10'(tm_s1) + 10'(tr_s1);
		bot_sum   = 10'(bl_s1) + 10'(bm_s1) + 10'(br_s1);
		left_sum  = 10'(tl_s1) + 10'(ml_s1) + 10'(bl_s1);
		right_sum = 10'(tr_s1) + 10'(mr_s1) + 10'(br_s1);
		// squares of |G| equal squares of G
		gx_sq     = 20'(gx_abs_s2) * 20'(gx_abs_s2);
		gy_sq     = 20'(gy_abs_s2) * 20'(gy_abs_s2);
		mag       = 21'(gx_sq) + 21'(gy_sq);
	end

	assign done    = done_q;
	assign is_edge = is_edge_q;

	`PEBT_ASSERT_NXT(a_req_reaches_s2, valid_s1, valid_s2)
	`PEBT_ASSERT_NXT(a_s2_gives_done, valid_s2, done)
	`PEBT_ASSERT_IMP(a_edge_only_with_done, is_edge, done)
	`PEBT_ASSERT_NXT(a_bright_centre_no_edge, valid_s2 && !dark_s2, !is_edge)

endmodule

`default_nettype wire

/* tb/tb_prewitt_edge_banded_threshold.sv */
`timescale 1ns / 1ps
// Self-checking bench for prewitt_edge_banded_threshold: directed windows, then random windows
// under several band settings and sender gap rates. Depends on pebt_pkg and the block's RTL.

module tb_prewitt_edge_banded_threshold;

	typedef struct packed {
		logic [7:0]       row;
		pebt_pkg::pixel_t tl, tm, tr, ml, c, mr, bl, bm, br;
	} window_t;

	typedef logic [15:0] reg_file_t [pebt_pkg::NUM_BANDS * 2];

	// holds the band settings as written and the edge flags still owed by the block
	class edge_scoreboard;
		logic [7:0]  dark_lvl [pebt_pkg::NUM_BANDS];
		logic [15:0] grad_lim [pebt_pkg::NUM_BANDS];
		bit          pending_edges [$];
		int          mismatches;

		function new();
			foreach (dark_lvl[i]) begin
				dark_lvl[i] = '0;
				grad_lim[i] = '0;
			end
			mismatches = 0;
		endfunction

		function void set_register(pebt_pkg::reg_index_t idx, logic [15:0] data);
			if (idx < pebt_pkg::REG_GRAD_BAND0)
				dark_lvl[idx[1:0]] = data[7:0];
			else
				grad_lim[idx[1:0]] = data;
		endfunction

		function bit predict_edge(window_t w);
			pebt_pkg::band_t band;
			int              top_sum, bot_sum, left_sum, right_sum, gx, gy;
			int unsigned     mag;
			if (w.row >= pebt_pkg::BAND0_ROW_MIN) band = pebt_pkg::BAND0;
			else if (w.row >= pebt_pkg::BAND1_ROW_MIN) band = pebt_pkg::BAND1;
			else if (w.row >= pebt_pkg::BAND2_ROW_MIN) band = pebt_pkg::BAND2;
			else band = pebt_pkg::BAND3;
			if (w.c >= dark_lvl[band])
				return 1'b0;
			top_sum = w.tl + w.tm + w.tr;
			bot_sum = w.bl + w.bm + w.br;
			left_sum = w.tl + w.ml + w.bl;
			right_sum = w.tr + w.mr + w.br;
			gx = bot_sum - top_sum;
			gy = right_sum - left_sum;
			mag = gx * gx + gy * gy;
			return mag > grad_lim[band];
		endfunction

		function void note_request(window_t w);
			pending_edges.push_back(predict_edge(w));
		endfunction

		function void check_result(logic actual);
			bit expected;
			if (pending_edges.size() == 0) begin
				$display("%0t: unexpected result, expected none actual is_edge=%0b",
					$time, actual);
				mismatches++;
			end else begin
				expected = pending_edges.pop_front();
				if (actual !== expected) begin
					$display("%0t: is_edge mismatch, expected %0b actual %0b",
						$time, expected, actual);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [7:0]  row_index = '0;
	logic [7:0]  top_left = '0, top_mid = '0, top_right = '0;
	logic [7:0]  mid_left = '0, center_pixel = '0, mid_right = '0;
	logic [7:0]  bottom_left = '0, bottom_mid = '0, bottom_right = '0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = pebt_pkg::REG_DARK_BAND0;
	logic [15:0] cfg_data = '0;
	logic        done;
	logic        is_edge;

	edge_scoreboard sb = new();
	int             idle_pct = 0;

	prewitt_edge_banded_threshold DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.row_index(row_index), .top_left(top_left), .top_mid(top_mid),
		.top_right(top_right), .mid_left(mid_left), .center_pixel(center_pixel),
		.mid_right(mid_right), .bottom_left(bottom_left), .bottom_mid(bottom_mid),
		.bottom_right(bottom_right), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .is_edge(is_edge)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(is_edge);
	end

	function automatic window_t mk(input logic [7:0] row, input pebt_pkg::pixel_t tl, tm, tr,
			ml, c, mr, bl, bm, br);
		window_t w;
		w = {row, tl, tm, tr, ml, c, mr, bl, bm, br};
		return w;
	endfunction

	// leaves start high after acceptance; the caller lowers it or sends the next request
	task automatic send_window(input window_t w);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		row_index <= w.row;
		top_left <= w.tl; top_mid <= w.tm; top_right <= w.tr;
		mid_left <= w.ml; center_pixel <= w.c; mid_right <= w.mr;
		bottom_left <= w.bl; bottom_mid <= w.bm; bottom_right <= w.br;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(w);
	endtask

	task automatic wait_drain();
		start <= 1'b0;
		while (sb.pending_edges.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_settings(input reg_file_t vals);
		pebt_pkg::reg_index_t r;
		r = r.first();
		repeat (r.num()) begin
			cfg_we <= 1'b1;
			cfg_index <= r;
			cfg_data <= vals[r];
			@(posedge clk);
			sb.set_register(r, vals[r]);
			r = r.next();
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		reg_file_t   regs;
		logic [7:0]  bounds [8];
		int          idle_plan [6];
		window_t     w;
		int          sel, base, spread;

		bounds = '{8'd0, 8'd59, 8'd60, 8'd79, 8'd80, 8'd109, 8'd110, 8'd255};
		idle_plan = '{0, 47, 0, 15, 47, 0};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset levels are zero, so nothing may be flagged
		send_window(mk(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
		send_window(mk(8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_window(mk(8'd70, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd9, 8'd0, 8'd0, 8'd0));
		wait_drain();

		// widest levels, zero limits: any dark window with a nonzero gradient is an edge
		regs = '{16'hAAFF, 16'h55FF, 16'hFFFF, 16'h00FF, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
		write_settings(regs);
		foreach (bounds[i])
			send_window(mk(bounds[i], 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0));
		send_window(mk(8'd120, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7));
		send_window(mk(8'd30, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
			8'd255, 8'd255));
		send_window(mk(8'd30, 8'd0, 8'd0, 8'd0, 8'd0, 8'd254, 8'd0, 8'd0, 8'd255, 8'd0));
		send_window(mk(8'd90, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0));
		wait_drain();

		// mixed levels and limits; gx=6, gy=8 sits exactly on a limit of 100
		regs = '{16'h0001, 16'hFF80, 16'h00FE, 16'h01FF, 16'd100, 16'hFFFF, 16'd99, 16'd1};
		write_settings(regs);
		send_window(mk(8'd110, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd8, 8'd0, 8'd6, 8'd0));
		send_window(mk(8'd79, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd8, 8'd0, 8'd6, 8'd0));
		send_window(mk(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd8, 8'd0, 8'd6, 8'd0));
		send_window(mk(8'd80, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
		send_window(mk(8'd109, 8'd0, 8'd0, 8'd255, 8'd0, 8'd127, 8'd255, 8'd0, 8'd255, 8'd255));
		send_window(mk(8'd59, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0));
		send_window(mk(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd254, 8'd0, 8'd0, 8'd1, 8'd1));
		wait_drain();

		foreach (idle_plan[p]) begin
			foreach (regs[i]) begin
				sel = $urandom_range(5);
				if (i < pebt_pkg::NUM_BANDS)
					regs[i] = {8'($urandom_range(255)),
						(sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom_range(255))};
				else if (sel == 0)
					regs[i] = 16'h0000;
				else if (sel == 1)
					regs[i] = 16'hFFFF;
				else if (sel < 4)
					regs[i] = 16'($urandom_range(3000));
				else
					regs[i] = 16'($urandom_range(65535));
			end
			write_settings(regs);
			idle_pct = idle_plan[p];
			repeat (75) begin
				sel = $urandom_range(99);
				w = window_t'(80'({$urandom, $urandom, $urandom}));
				if ($urandom_range(3) == 0)
					w.row = bounds[$urandom_range(7)];
				if (sel < 40) begin
					// near-flat patch, small gradients around the limits
					base = $urandom_range(200);
					spread = $urandom_range(40);
					w.tl = 8'(base + $urandom_range(spread));
					w.tm = 8'(base + $urandom_range(spread));
					w.tr = 8'(base + $urandom_range(spread));
					w.ml = 8'(base + $urandom_range(spread));
					w.c  = 8'(base + $urandom_range(spread));
					w.mr = 8'(base + $urandom_range(spread));
					w.bl = 8'(base + $urandom_range(spread));
					w.bm = 8'(base + $urandom_range(spread));
					w.br = 8'(base + $urandom_range(spread));
				end else if (sel < 70) begin
					w.c = 8'($urandom_range(31));
				end
				send_window(w);
			end
			wait_drain();
		end

		if (sb.mismatches == 0 && sb.pending_edges.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
